### sv/tbu_pkg.sv
// ----------------------------------------------------------------------------
// tbu_pkg
// shared constants and state type of the triangle tangent and binormal unit
// ----------------------------------------------------------------------------
package tbu_pkg;

   localparam int FRAC_BITS = 16;
   localparam int CRD_W     = 32;
   localparam int DLT_W     = CRD_W + 1;
   localparam int PRD_W     = 2 * DLT_W + 1;
   localparam int DIV_W     = PRD_W + FRAC_BITS + 1;
   localparam int CNT_W     = 7;
   localparam int NRM_BITS  = 30;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_EVAL,
      ST_NORM,
      ST_SQR,
      ST_SQRT,
      ST_DIV,
      ST_FIN
   } state_type;

endpackage

### sv/triangle_tangent_binormal_unit.sv
// ----------------------------------------------------------------------------
// triangle_tangent_binormal_unit
// per-triangle tangent and binormal from three streamed vertices
// ----------------------------------------------------------------------------
// usage: vertices come in on the req_ stream, three to a triangle. the first
// two are stored; the third starts the computation and one result per
// triangle leaves on the rsp_ stream. rsp_tuser carries the degenerate flag,
// and a degenerate triangle returns all zero vectors.
// after the third vertex the unit runs 14 serial products, normalization
// shifting, 3 squares, 32 square root steps and 6 restoring divisions; a
// degenerate triangle skips the steps after the products. the shift-add
// multiplier and the restoring divider handle one bit per cycle.
// the first two vertices of a triangle are only stored, back to back.
// a result waits in the output register until taken; new vertices are
// accepted meanwhile, and a finished triangle holds until the register frees.
// reset clears the state, the vertex position and the output valid; stored
// vertex data is not cleared.
// ----------------------------------------------------------------------------
module triangle_tangent_binormal_unit
   import tbu_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [159:0] req_tdata,   // pos_x, pos_y, pos_z, tex_u, tex_v
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [191:0] rsp_tdata,   // tangent_x/y/z, binormal_x/y/z
   output logic         rsp_tuser    // degenerate
);

   state_type          state_ff, state_in;
   logic [1:0]         slot_ff, slot_in;
   logic [CRD_W-1:0]   pos_ff [6], pos_in [6];
   logic [CRD_W-1:0]   tex_ff [4], tex_in [4];
   logic [DLT_W-1:0]   e1_ff [3], e1_in [3];
   logic [DLT_W-1:0]   e2_ff [3], e2_in [3];
   logic [DLT_W-1:0]   du1_ff, du1_in, dv1_ff, dv1_in, du2_ff, du2_in, dv2_ff, dv2_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [3:0]         idx_ff, idx_in;
   logic [PRD_W-1:0]   mc_ff, mc_in, acc_ff, acc_in;
   logic [DLT_W-1:0]   mr_ff, mr_in;
   logic [PRD_W-1:0]   res_ff [7], res_in [7];
   logic [PRD_W-1:0]   nm_ff [3], nm_in [3];
   logic [PRD_W-1:0]   dm_ff, dm_in;
   logic [2:0]         tsg_ff, tsg_in, bsg_ff, bsg_in;
   logic               degen_ff, degen_in;
   logic [63:0]        sv_ff, sv_in, sr_ff, sr_in, sb_ff, sb_in;
   logic [31:0]        len_ff, len_in;
   logic [DIV_W-1:0]   dn_ff, dn_in;
   logic [PRD_W-1:0]   dd_ff, dd_in, rem_ff, rem_in;
   logic [32:0]        q_ff, q_in;
   logic               qov_ff, qov_in;
   logic [CRD_W-1:0]   out_ff [6], out_in [6];
   logic               rsp_valid_ff, rsp_valid_in;
   logic [191:0]       rsp_data_ff, rsp_data_in;
   logic               rsp_user_ff, rsp_user_in;

   logic               in_xfer;
   logic [CRD_W-1:0]   in_f [5];

   assign req_tready = (state_ff == ST_IDLE);
   assign in_xfer    = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   always_comb begin
      for (int k = 0; k < 5; k++) in_f[k] = req_tdata[k*CRD_W +: CRD_W];
   end

   always_comb begin
      logic [2:0]       k3;
      logic [1:0]       i2;
      logic [DLT_W-1:0] opa, opb;
      logic             neg;
      logic [PRD_W-1:0] addend;
      logic [PRD_W-1:0] det, orv, bmag;
      logic [63:0]      rb;
      logic [PRD_W:0]   r2;
      logic             ge;
      logic [32:0]      qn;
      logic             qovn;
      logic [31:0]      ov;
      logic [2:0]       ri;
      state_in     = state_ff;
      slot_in      = slot_ff;
      pos_in       = pos_ff;
      tex_in       = tex_ff;
      e1_in        = e1_ff;
      e2_in        = e2_ff;
      du1_in       = du1_ff;
      dv1_in       = dv1_ff;
      du2_in       = du2_ff;
      dv2_in       = dv2_ff;
      cnt_in       = cnt_ff;
      idx_in       = idx_ff;
      mc_in        = mc_ff;
      mr_in        = mr_ff;
      acc_in       = acc_ff;
      res_in       = res_ff;
      nm_in        = nm_ff;
      dm_in        = dm_ff;
      tsg_in       = tsg_ff;
      bsg_in       = bsg_ff;
      degen_in     = degen_ff;
      sv_in        = sv_ff;
      sr_in        = sr_ff;
      sb_in        = sb_ff;
      len_in       = len_ff;
      dn_in        = dn_ff;
      dd_in        = dd_ff;
      rem_in       = rem_ff;
      q_in         = q_ff;
      qov_in       = qov_ff;
      out_in       = out_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      k3     = idx_ff[3:1];
      i2     = '0;
      opa    = '0;
      opb    = '0;
      neg    = 1'b0;
      addend = '0;
      det    = res_ff[0];
      orv    = nm_ff[0] | nm_ff[1] | nm_ff[2];
      bmag   = '0;
      rb     = sr_ff + sb_ff;
      r2     = {rem_ff, dn_ff[DIV_W-1]};
      ge     = (r2 >= {1'b0, dd_ff});
      qn     = {q_ff[31:0], ge};
      qovn   = qov_ff | q_ff[32];
      ov     = '0;
      ri     = 3'(idx_ff[2:0] + 3'd1);

      // serial product operand selection
      if (k3 == 3'd0) begin
         opa = idx_ff[0] ? du2_ff : du1_ff;
         opb = idx_ff[0] ? dv1_ff : dv2_ff;
      end else if (k3 <= 3'd3) begin
         i2  = 2'(k3 - 3'd1);
         opa = idx_ff[0] ? dv1_ff : dv2_ff;
         opb = idx_ff[0] ? e2_ff[i2] : e1_ff[i2];
      end else begin
         i2  = 2'(k3 - 3'd4);
         opa = idx_ff[0] ? du2_ff : du1_ff;
         opb = idx_ff[0] ? e1_ff[i2] : e2_ff[i2];
      end

      case (state_ff)
         ST_IDLE: begin
            if (in_xfer) begin
               if (slot_ff == 2'd2) begin
                  for (int k = 0; k < 3; k++) begin
                     e1_in[k] = {pos_ff[3+k][31], pos_ff[3+k]} - {pos_ff[k][31], pos_ff[k]};
                     e2_in[k] = {in_f[k][31], in_f[k]} - {pos_ff[k][31], pos_ff[k]};
                  end
                  du1_in   = {tex_ff[2][31], tex_ff[2]} - {tex_ff[0][31], tex_ff[0]};
                  dv1_in   = {tex_ff[3][31], tex_ff[3]} - {tex_ff[1][31], tex_ff[1]};
                  du2_in   = {in_f[3][31], in_f[3]} - {tex_ff[0][31], tex_ff[0]};
                  dv2_in   = {in_f[4][31], in_f[4]} - {tex_ff[1][31], tex_ff[1]};
                  slot_in  = 2'd0;
                  cnt_in   = '0;
                  idx_in   = '0;
                  state_in = ST_MUL;
               end else if (slot_ff == 2'd1) begin
                  for (int k = 0; k < 3; k++) pos_in[3+k] = in_f[k];
                  tex_in[2] = in_f[3];
                  tex_in[3] = in_f[4];
                  slot_in   = 2'd2;
               end else begin
                  for (int k = 0; k < 3; k++) pos_in[k] = in_f[k];
                  tex_in[0] = in_f[3];
                  tex_in[1] = in_f[4];
                  slot_in   = 2'd1;
               end
            end
         end
         ST_MUL: begin
            if (cnt_ff == '0) begin
               mc_in = {{(PRD_W-DLT_W){opa[DLT_W-1]}}, opa};
               mr_in = opb;
               if (!idx_ff[0]) acc_in = '0;
               cnt_in = CNT_W'(1);
            end else begin
               neg    = (cnt_ff == CNT_W'(DLT_W)) ^ idx_ff[0];
               addend = neg ? ~mc_ff : mc_ff;
               if (mr_ff[0]) acc_in = acc_ff + addend + PRD_W'(neg);
               mc_in = {mc_ff[PRD_W-2:0], 1'b0};
               mr_in = {1'b0, mr_ff[DLT_W-1:1]};
               if (cnt_ff == CNT_W'(DLT_W)) begin
                  cnt_in = '0;
                  idx_in = idx_ff + 4'd1;
                  if (idx_ff[0]) res_in[k3] = acc_in;
                  if (idx_ff == 4'd13) state_in = ST_EVAL;
               end else begin
                  cnt_in = cnt_ff + CNT_W'(1);
               end
            end
         end
         ST_EVAL: begin
            degen_in = (det == '0) ||
                       (res_ff[1] == '0 && res_ff[2] == '0 && res_ff[3] == '0);
            dm_in    = det[PRD_W-1] ? PRD_W'(-det) : det;
            for (int k = 0; k < 3; k++) begin
               nm_in[k]  = res_ff[1+k][PRD_W-1] ? PRD_W'(-res_ff[1+k]) : res_ff[1+k];
               tsg_in[k] = res_ff[1+k][PRD_W-1] ^ det[PRD_W-1];
               bsg_in[k] = res_ff[4+k][PRD_W-1] ^ det[PRD_W-1];
            end
            state_in = degen_in ? ST_FIN : ST_NORM;
         end
         ST_NORM: begin
            if (|orv[PRD_W-1:NRM_BITS]) begin
               for (int k = 0; k < 3; k++) nm_in[k] = {1'b0, nm_ff[k][PRD_W-1:1]};
            end else if (!orv[NRM_BITS-1]) begin
               for (int k = 0; k < 3; k++) nm_in[k] = {nm_ff[k][PRD_W-2:0], 1'b0};
            end else begin
               cnt_in   = '0;
               idx_in   = '0;
               acc_in   = '0;
               state_in = ST_SQR;
            end
         end
         ST_SQR: begin
            if (cnt_ff == '0) begin
               mc_in  = nm_ff[idx_ff[1:0]];
               mr_in  = nm_ff[idx_ff[1:0]][DLT_W-1:0];
               cnt_in = CNT_W'(1);
            end else begin
               if (mr_ff[0]) acc_in = acc_ff + mc_ff;
               mc_in = {mc_ff[PRD_W-2:0], 1'b0};
               mr_in = {1'b0, mr_ff[DLT_W-1:1]};
               if (cnt_ff == CNT_W'(DLT_W)) begin
                  cnt_in = '0;
                  idx_in = idx_ff + 4'd1;
                  if (idx_ff == 4'd2) begin
                     sv_in    = acc_in[63:0];
                     sr_in    = '0;
                     sb_in    = 64'd1 << 62;
                     state_in = ST_SQRT;
                  end
               end else begin
                  cnt_in = cnt_ff + CNT_W'(1);
               end
            end
         end
         ST_SQRT: begin
            if (sv_ff >= rb) begin
               sv_in = sv_ff - rb;
               sr_in = {1'b0, sr_ff[63:1]} + sb_ff;
            end else begin
               sr_in = {1'b0, sr_ff[63:1]};
            end
            sb_in = {2'b00, sb_ff[63:2]};
            if (cnt_ff == CNT_W'(31)) begin
               len_in   = sr_in[31:0];
               cnt_in   = '0;
               idx_in   = '0;
               state_in = ST_DIV;
            end else begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end
         ST_DIV: begin
            if (cnt_ff == '0) begin
               if (idx_ff < 4'd3) begin
                  dn_in = DIV_W'({nm_ff[idx_ff[1:0]][NRM_BITS-1:0], {NRM_BITS{1'b0}}})
                        + DIV_W'(len_ff[31:1]);
                  dd_in = PRD_W'(len_ff);
               end else begin
                  bmag  = res_ff[ri][PRD_W-1] ? PRD_W'(-res_ff[ri]) : res_ff[ri];
                  dn_in = (DIV_W'(bmag) << FRAC_BITS) + DIV_W'(dm_ff[PRD_W-1:1]);
                  dd_in = dm_ff;
               end
               rem_in = '0;
               q_in   = '0;
               qov_in = 1'b0;
               cnt_in = CNT_W'(1);
            end else begin
               rem_in = ge ? PRD_W'(r2 - {1'b0, dd_ff}) : r2[PRD_W-1:0];
               dn_in  = {dn_ff[DIV_W-2:0], 1'b0};
               q_in   = qn;
               qov_in = qovn;
               if (cnt_ff == CNT_W'(DIV_W)) begin
                  if (idx_ff < 4'd3) begin
                     ov = tsg_ff[idx_ff[1:0]] ? 32'(-qn[31:0]) : qn[31:0];
                  end else if (bsg_ff[2'(idx_ff - 4'd3)]) begin
                     ov = (qovn || qn > 33'h080000000) ? 32'h80000000 : 32'(-qn[31:0]);
                  end else begin
                     ov = (qovn || qn[32] || qn[31]) ? 32'h7FFFFFFF : qn[31:0];
                  end
                  out_in[idx_ff[2:0]] = ov;
                  cnt_in = '0;
                  idx_in = idx_ff + 4'd1;
                  if (idx_ff == 4'd5) state_in = ST_FIN;
               end else begin
                  cnt_in = cnt_ff + CNT_W'(1);
               end
            end
         end
         ST_FIN: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_user_in  = degen_ff;
               for (int k = 0; k < 6; k++)
                  rsp_data_in[k*CRD_W +: CRD_W] = degen_ff ? '0 : out_ff[k];
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         slot_ff      <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         slot_ff      <= slot_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff      <= pos_in;
      tex_ff      <= tex_in;
      e1_ff       <= e1_in;
      e2_ff       <= e2_in;
      du1_ff      <= du1_in;
      dv1_ff      <= dv1_in;
      du2_ff      <= du2_in;
      dv2_ff      <= dv2_in;
      cnt_ff      <= cnt_in;
      idx_ff      <= idx_in;
      mc_ff       <= mc_in;
      mr_ff       <= mr_in;
      acc_ff      <= acc_in;
      res_ff      <= res_in;
      nm_ff       <= nm_in;
      dm_ff       <= dm_in;
      tsg_ff      <= tsg_in;
      bsg_ff      <= bsg_in;
      degen_ff    <= degen_in;
      sv_ff       <= sv_in;
      sr_ff       <= sr_in;
      sb_ff       <= sb_in;
      len_ff      <= len_in;
      dn_ff       <= dn_in;
      dd_ff       <= dd_in;
      rem_ff      <= rem_in;
      q_ff        <= q_in;
      qov_ff      <= qov_in;
      out_ff      <= out_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

endmodule
